### rtl/core/mwdp_pkg.sv
// ----------------------------------------------------------------------------
// mwdp_pkg
// Shared widths, types and constants of the sliding-window max digit product.
// ----------------------------------------------------------------------------
package mwdp_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int DIGIT_W    = 4;
   localparam int PRODUCT_W  = 51;
   localparam int LEN_W      = 5;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int FULL_W     = PRODUCT_W + DIGIT_W;

   localparam logic [LEN_W-1:0]     LEN_RESET   = LEN_W'(13);
   localparam logic [PRODUCT_W-1:0] PRODUCT_CAP = {PRODUCT_W{1'b1}};

   typedef logic [PRODUCT_W-1:0] product_type;
   typedef logic [DIGIT_W-1:0]   digit_type;

   // control handed from the chain front end to the max tracker
   typedef struct packed {
      logic             valid;
      logic             last;
      logic             window_ok;
      logic [IDX_W-1:0] sel;
   } stage_type;

endpackage

### rtl/core/mwdp_req_if.sv
// ----------------------------------------------------------------------------
// mwdp_req_if
// Digit input channel: one digit per transaction, with end-of-string flag.
// ----------------------------------------------------------------------------
interface mwdp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mwdp_pkg::DIGIT_W-1:0]  digit;
   logic                          last;

   modport source (output valid, output digit, output last, input ready);
   modport sink   (input valid, input digit, input last, output ready);
endinterface

### rtl/core/mwdp_rsp_if.sv
// ----------------------------------------------------------------------------
// mwdp_rsp_if
// Result channel: one transaction per string with the maximum window product.
// ----------------------------------------------------------------------------
interface mwdp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mwdp_pkg::PRODUCT_W-1:0]  max_product;
   logic                            full_window_seen;

   modport source (output valid, output max_product, output full_window_seen, input ready);
   modport sink   (input valid, input max_product, input full_window_seen, output ready);
endinterface

### rtl/core/mwdp_cell.sv
// ----------------------------------------------------------------------------
// mwdp_cell
// One chain cell: holds the product of the newest k+1 digits, built from the
// left neighbor's previous product times the incoming digit, saturating.
// ----------------------------------------------------------------------------
module mwdp_cell (
   input  logic                  clock,
   input  logic                  enable,
   input  mwdp_pkg::product_type left,
   input  mwdp_pkg::digit_type   digit,
   output mwdp_pkg::product_type product
);
   import mwdp_pkg::*;

   logic [FULL_W-1:0] full;
   product_type       product_ff;
   product_type       product_in;

   always_comb begin
      full = {{DIGIT_W{1'b0}}, left} * {{PRODUCT_W{1'b0}}, digit};
      if (full > {{DIGIT_W{1'b0}}, PRODUCT_CAP}) begin
         product_in = PRODUCT_CAP;
      end else begin
         product_in = full[PRODUCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

### rtl/core/mwdp_tracker.sv
// ----------------------------------------------------------------------------
// mwdp_tracker
// Picks the window product out of the chain, keeps the running maximum and
// drives the result register at the end of each string.
// ----------------------------------------------------------------------------
module mwdp_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  mwdp_pkg::stage_type   stage,
   input  mwdp_pkg::product_type products [mwdp_pkg::MAX_WINDOW],
   output logic                  advance,
   mwdp_rsp_if.source            rsp
);
   import mwdp_pkg::*;

   product_type best_ff, best_in;
   logic        any_ff, any_in;
   logic        rsp_valid_ff, rsp_valid_in;
   product_type rsp_prod_ff, rsp_prod_in;
   logic        rsp_any_ff, rsp_any_in;

   product_type win;
   product_type new_best;
   logic        new_any;
   logic        out_free;

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      advance  = !(stage.valid && stage.last) || out_free;
      win      = products[stage.sel];
      new_best = (stage.window_ok && (win > best_ff)) ? win : best_ff;
      new_any  = any_ff || stage.window_ok;

      best_in      = best_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_prod_in  = rsp_prod_ff;
      rsp_any_in   = rsp_any_ff;

      if (stage.valid && advance) begin
         if (stage.last) begin
            rsp_valid_in = 1'b1;
            rsp_prod_in  = new_best;
            rsp_any_in   = new_any;
            best_in      = '0;
            any_in       = 1'b0;
         end else begin
            best_in = new_best;
            any_in  = new_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prod_ff <= rsp_prod_in;
      rsp_any_ff  <= rsp_any_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.max_product      = rsp_prod_ff;
   assign rsp.full_window_seen = rsp_any_ff;

   // no window in the string means the reported maximum is zero
   a_no_window_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_any_ff |-> rsp_prod_ff == '0)
      else $error("result without full window carries nonzero product");

   // end of string clears the running maximum
   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      stage.valid && stage.last && advance |=> best_ff == '0 && !any_ff)
      else $error("running maximum not cleared after end of string");

   // a new result only comes from an end-of-string digit
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage.valid && stage.last))
      else $error("result raised without end-of-string digit");

endmodule

### rtl/core/max_window_digit_product.sv
// ----------------------------------------------------------------------------
// max_window_digit_product
// Maximum product of any window of consecutive decimal digits in a string.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one digit (0..9) per transaction; last marks the final digit
//   of a string. rsp carries one transaction per string: the largest product
//   over every full window of window_length digits, and full_window_seen,
//   which is 0 (with a zero product) when the string was shorter than the
//   window. csr_we/csr_wdata set window_length (0 acts as 1, above 16 as 16);
//   write it only between strings.
//   Throughput: one digit per cycle. A chain of 16 cells, each with one
//   51x4 multiplier, updates all partial products in the cycle a digit is
//   taken; the next cycle selects the window product and updates the max.
//   The last digit passes the stage register before the result register takes the result.
//   A stalled result register blocks only an end-of-string digit held in the
//   stage register; req.ready then drops until rsp is taken. Other digits keep flowing.
//   Reset (synchronous): clears string state and the result valid flag and
//   restores window_length to 13.
// ----------------------------------------------------------------------------
module max_window_digit_product (
   input  logic                          clock,
   input  logic                          reset,
   mwdp_req_if.sink                      req,
   mwdp_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  logic [mwdp_pkg::LEN_W-1:0]    csr_wdata
);
   import mwdp_pkg::*;

   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_eff;
   logic [CNT_W-1:0] seen_ff, seen_in, seen_next;
   stage_type        stage_ff, stage_in;
   logic             advance;
   logic             accept;

   product_type left     [MAX_WINDOW];
   product_type products [MAX_WINDOW];

   assign req.ready = !stage_ff.valid || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_WINDOW)) begin
         len_eff = LEN_W'(MAX_WINDOW);
      end else begin
         len_eff = len_ff;
      end

      seen_next = (seen_ff < CNT_W'(MAX_WINDOW)) ? seen_ff + CNT_W'(1) : seen_ff;

      seen_in = seen_ff;
      if (accept) begin
         seen_in = req.last ? '0 : seen_next;
      end

      stage_in           = stage_ff;
      if (req.ready) begin
         stage_in.valid     = accept;
         stage_in.last      = req.last;
         stage_in.window_ok = seen_next >= CNT_W'(len_eff);
         stage_in.sel       = IDX_W'(len_eff - LEN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_RESET;
         seen_ff  <= '0;
         stage_ff <= '0;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         seen_ff  <= seen_in;
         stage_ff <= stage_in;
      end
   end

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left[i] = PRODUCT_W'(1);
      end else begin : g_body
         assign left[i] = products[i-1];
      end

      mwdp_cell u_cell (
         .clock   (clock),
         .enable  (accept),
         .left    (left[i]),
         .digit   (req.digit),
         .product (products[i])
      );
   end

   mwdp_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage_ff),
      .products (products),
      .advance  (advance),
      .rsp      (rsp)
   );

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_WINDOW))
      else $error("digit count beyond window capacity");

   a_seen_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req.last |=> seen_ff == '0)
      else $error("digit count not cleared at end of string");

   // head cell holds the newest digit
   a_head_cell: assert property (@(posedge clock) disable iff (reset)
      accept |=> products[0] == PRODUCT_W'($past(req.digit)))
      else $error("head cell does not hold the accepted digit");

endmodule

### bench/mwdp_checker.sv
// ----------------------------------------------------------------------------
// mwdp_checker
// Watches the digit, result and register ports of max_window_digit_product.
// Keeps its own copy of the string state, works out the expected maximum
// window product for every end-of-string digit, and compares each result
// transaction field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module mwdp_checker (
   input  logic                       clock,
   input  logic                       reset,
   mwdp_req_if                        req,
   mwdp_rsp_if                        rsp,
   input  logic                       csr_we,
   input  logic [mwdp_pkg::LEN_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);
   import mwdp_pkg::*;

   typedef struct packed {
      product_type max_product;
      logic        full_window_seen;
   } string_result_type;

   digit_type         recent_digits [MAX_WINDOW];
   logic [CNT_W-1:0]  string_digits;
   product_type       best_product;
   logic [IDX_W-1:0]  next_slot;
   logic              window_seen;
   logic [LEN_W-1:0]  window_length;
   string_result_type expected_maxima [$];

   function automatic int span_of(input logic [LEN_W-1:0] len);
      if (len == '0) return 1;
      if (len > MAX_WINDOW) return MAX_WINDOW;
      return int'(len);
   endfunction

   // product of the newest span digits, clamped at the product cap
   function automatic product_type window_product(input int span);
      logic [63:0] acc;
      int          pos;
      acc = 64'd1;
      for (int k = 0; k < span; k++) begin
         pos = (int'(next_slot) + 2 * MAX_WINDOW - 1 - k) % MAX_WINDOW;
         acc = acc * recent_digits[pos];
         if (acc > 64'(PRODUCT_CAP)) acc = 64'(PRODUCT_CAP);
      end
      return product_type'(acc);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic absorb_digit(input digit_type d, input logic lst);
      int          span;
      product_type prod;
      span = span_of(window_length);
      recent_digits[next_slot] = d;
      next_slot = IDX_W'((int'(next_slot) + 1) % MAX_WINDOW);
      if (string_digits < MAX_WINDOW) string_digits++;
      if (int'(string_digits) >= span) begin
         prod = window_product(span);
         if (prod > best_product) best_product = prod;
         window_seen = 1'b1;
      end
      if (lst) begin
         expected_maxima.push_back('{best_product, window_seen});
         string_digits = '0;
         best_product  = '0;
         next_slot     = '0;
         window_seen   = 1'b0;
      end
   endtask

   task automatic check_result(input product_type got_prod, input logic got_seen);
      string_result_type want;
      if (expected_maxima.size() == 0) begin
         report_mismatch($sformatf("unexpected result transaction: product=%0d seen=%0b",
                                   got_prod, got_seen));
         return;
      end
      want = expected_maxima.pop_front();
      if (got_prod !== want.max_product)
         report_mismatch($sformatf("max_product %0d, expected %0d",
                                   got_prod, want.max_product));
      if (got_seen !== want.full_window_seen)
         report_mismatch($sformatf("full_window_seen %0b, expected %0b",
                                   got_seen, want.full_window_seen));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         string_digits = '0;
         best_product  = '0;
         next_slot     = '0;
         window_seen   = 1'b0;
         window_length = LEN_RESET;
         expected_maxima.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_result(rsp.max_product, rsp.full_window_seen);
         if (req.valid && req.ready) absorb_digit(req.digit, req.last);
         // a new length takes effect from the next digit on
         if (csr_we) window_length = csr_wdata;
      end
      pending_count = expected_maxima.size();
   end

endmodule

### bench/tb_max_window_digit_product.sv
// ----------------------------------------------------------------------------
// tb_max_window_digit_product
// Stimulus and verdict for the sliding-window max digit product. A directed
// opening covers short strings, the zero length and product saturation; then
// random digit strings run through many window lengths under four idling
// modes on the digit and result channels. mwdp_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_max_window_digit_product;
   import mwdp_pkg::*;

   localparam int PHASE_DIGITS  = 88;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_PHASES    = 13;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             csr_we    = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;
   int               fail_count;
   int               pending_count;
   int               sender_idle_pct    = 0;
   int               receiver_stall_pct = 0;
   int               cycle_count        = 0;

   logic [LEN_W-1:0] phase_lengths [NUM_PHASES] =
      '{5'd13, 5'd1, 5'd31, 5'd0, 5'd16, 5'd2, 5'd17, 5'd5, 5'd9, 5'd3, 5'd20, 5'd12, 5'd7};

   mwdp_req_if req_ch ();
   mwdp_rsp_if rsp_ch ();

   max_window_digit_product i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   mwdp_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;  receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 77; receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;  receiver_stall_pct = 77;
         end
         default: begin
            sender_idle_pct = 32; receiver_stall_pct = 32;
         end
      endcase
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_digit(input digit_type d, input logic lst);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.digit <= d;
      req_ch.last  <= lst;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly nonzero decimal digits; some zeros and some out-of-range values
   function automatic digit_type pick_digit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return digit_type'($urandom_range(10, 15));
      return digit_type'($urandom_range(1, 9));
   endfunction

   // string lengths cluster around the window edge
   function automatic int pick_string_length(input int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return span;
      if (r < 40 && span > 1) return span - 1;
      if (r < 50) return span + 1;
      return $urandom_range(1, span + 20);
   endfunction

   initial begin
      int span;
      int n;
      int sent;
      int strings;

      req_ch.valid = 1'b0;
      req_ch.digit = '0;
      req_ch.last  = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // window of 13 after reset: twelve digits never fill it
      for (int i = 0; i < 12; i++) send_digit(4'd9, i == 11);
      wait_drain();
      write_length(5'd0);
      send_digit(4'd0, 1'b1);
      send_digit(4'd15, 1'b1);
      wait_drain();
      write_length(5'd14);
      // fourteen digits of fifteen overflow the product width
      for (int i = 0; i < 14; i++) send_digit(4'd15, i == 13);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drain();
         write_length(phase_lengths[ph]);
         set_idling(idle_mode_type'(ph % 4));
         span = (phase_lengths[ph] == '0) ? 1 :
                (phase_lengths[ph] > MAX_WINDOW) ? MAX_WINDOW : int'(phase_lengths[ph]);
         sent    = 0;
         strings = 0;
         while (sent < PHASE_DIGITS) begin
            n = pick_string_length(span);
            for (int i = 0; i < n; i++) send_digit(pick_digit(), i == n - 1);
            sent += n;
            strings++;
            if (ph == 6 && strings == 3) wait_drain();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
